FILE: design/cpr_pkg.sv
// shared types and constants for the impulse response peak refiner
`default_nettype none

package cpr_pkg;

   // default sample width and longest searched response
   localparam int SAMPLE_BITS_DEF = 16;
   localparam int MAX_LENGTH_DEF  = 4096;

   // fixed result field widths
   localparam int PEAK_W = 12;
   localparam int FRAC_W = 16;

   // the offset is 0.5 * ratio in Q15, so the quotient carries 14 fraction bits
   localparam int FRAC_SHIFT = 14;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_RE,
      ST_MUL_IM,
      ST_SUM,
      ST_ROOT,
      ST_UPDATE,
      ST_DIV_SETUP,
      ST_DIV_CHECK,
      ST_DIV_STEP,
      ST_FINISH
   } state_type;

endpackage

`default_nettype wire

FILE: design/cir_peak_parabolic_refine_top.sv
// peak search with parabolic refinement over a complex impulse response
//
// usage:
//   req_ channel carries one complex sample per transaction, req_last marks the
//   final sample of a response. rsp_ channel carries one result per response:
//   the peak index, the Q15 fractional offset and the interpolated flag.
//   each sample is finished before the next sample can be accepted: one
//   shared multiplier squares both parts, then a bit-serial square root
//   produces one magnitude bit per cycle. req_stall is high while a sample
//   is being worked on, while the divider runs and while a result waits.
//   after the last sample, a restoring divider forms the offset one quotient
//   bit per cycle; its steps are skipped when no refinement is done or the
//   ratio reaches one, and the result is loaded once the output register
//   is free.
//   the result sits in an output register; if rsp_stall holds it, samples of
//   the next response are still taken, and only the next result waits.
//   synchronous reset clears the search state and drops rsp_valid.
//   samples at index MAX_LENGTH or beyond are ignored by the search.
`default_nettype none

module cir_peak_parabolic_refine_top #(
   parameter int SAMPLE_BITS = cpr_pkg::SAMPLE_BITS_DEF,
   parameter int MAX_LENGTH  = cpr_pkg::MAX_LENGTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // sample channel
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic signed [SAMPLE_BITS-1:0]     req_sample_re,
   input  wire logic signed [SAMPLE_BITS-1:0]     req_sample_im,
   input  wire logic                              req_last,
   // result channel
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [cpr_pkg::PEAK_W-1:0]             rsp_peak_index,
   output logic signed [cpr_pkg::FRAC_W-1:0]      rsp_frac_offset,
   output logic                                   rsp_interpolated
);

   localparam int SB      = SAMPLE_BITS;
   localparam int MAG_W   = SB + 1;
   localparam int RAD_W   = 2 * SB;
   localparam int REM_W   = SB + 3;
   localparam int DEN_W   = MAG_W + 3;
   localparam int Q_W     = cpr_pkg::FRAC_SHIFT + 1;
   localparam int POS_W   = (MAX_LENGTH > 2) ? $clog2(MAX_LENGTH) : 1;
   localparam int CNT_W   = $clog2(MAX_LENGTH + 1);
   localparam int ITER_N  = (SB > cpr_pkg::FRAC_SHIFT) ? SB : cpr_pkg::FRAC_SHIFT;
   localparam int ITER_W  = $clog2(ITER_N);

   cpr_pkg::state_type state_ff, state_in;

   // input capture
   logic signed [SB-1:0] re_ff, im_ff;
   logic                 last_ff;

   // shared multiplier and square root working registers
   logic [RAD_W-1:0]     prod_ff;
   logic [RAD_W-1:0]     rad_ff;
   logic [REM_W-1:0]     rem_ff;
   logic [SB-1:0]        root_ff;
   logic [ITER_W-1:0]    iter_ff;

   // search state
   logic [MAG_W-1:0]     best_mag_ff, left_mag_ff, right_mag_ff, prev_mag_ff;
   logic [POS_W-1:0]     best_pos_ff;
   logic [CNT_W-1:0]     count_ff;
   logic                 right_pend_ff, have_best_ff;

   // divider working registers
   logic signed [DEN_W-1:0] diff_ff, den_ff;
   logic                    refine_ff, neg_ff, done_ff;
   logic [DEN_W-1:0]        dabs_ff, drem_ff;
   logic [Q_W-1:0]          quot_ff;

   // output register
   logic                             rsp_valid_ff;
   logic [cpr_pkg::PEAK_W-1:0]       rsp_peak_ff;
   logic signed [cpr_pkg::FRAC_W-1:0] rsp_frac_ff;
   logic                             rsp_interp_ff;

   logic accept, out_load;
   logic signed [SB-1:0]    mul_op;
   logic signed [RAD_W-1:0] mul_prod;
   logic [REM_W-1:0]        rem_shift, rem_trial;
   logic [MAG_W-1:0]        mag;
   logic                    in_range;
   logic signed [DEN_W-1:0] den_calc, diff_calc;
   logic [DEN_W-1:0]        diff_abs, den_abs;
   logic [DEN_W:0]          drem_shift;
   logic [cpr_pkg::FRAC_W-1:0] quot_ext;

   assign accept = req_valid && !req_stall;

   // shared multiplier, squares the real part then the imaginary part
   assign mul_op   = (state_ff == cpr_pkg::ST_MUL_RE) ? re_ff : im_ff;
   assign mul_prod = mul_op * mul_op;

   // one square root digit per cycle
   assign rem_shift = {rem_ff[REM_W-3:0], rad_ff[RAD_W-1:RAD_W-2]};
   assign rem_trial = REM_W'({root_ff, 2'b01});
   assign mag       = MAG_W'(root_ff);

   assign in_range = count_ff < CNT_W'(MAX_LENGTH);

   // parabola numerator and denominator
   assign diff_calc = $signed(DEN_W'(left_mag_ff)) - $signed(DEN_W'(right_mag_ff));
   assign den_calc  = $signed(DEN_W'(left_mag_ff)) - $signed(DEN_W'({best_mag_ff, 1'b0}))
                      + $signed(DEN_W'(right_mag_ff));

   assign diff_abs = diff_ff[DEN_W-1] ? DEN_W'(-diff_ff) : DEN_W'(diff_ff);
   assign den_abs  = den_ff[DEN_W-1] ? DEN_W'(-den_ff) : DEN_W'(den_ff);

   // one quotient bit per cycle
   assign drem_shift = {drem_ff, 1'b0};
   assign quot_ext   = cpr_pkg::FRAC_W'(quot_ff);

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cpr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and handshake outputs
   always_comb begin
      state_in  = state_ff;
      req_stall = (state_ff != cpr_pkg::ST_IDLE);
      out_load  = 1'b0;
      case (state_ff)
         cpr_pkg::ST_IDLE: begin
            if (req_valid) state_in = cpr_pkg::ST_MUL_RE;
         end
         cpr_pkg::ST_MUL_RE:    state_in = cpr_pkg::ST_MUL_IM;
         cpr_pkg::ST_MUL_IM:    state_in = cpr_pkg::ST_SUM;
         cpr_pkg::ST_SUM:       state_in = cpr_pkg::ST_ROOT;
         cpr_pkg::ST_ROOT: begin
            if (iter_ff == '0) state_in = cpr_pkg::ST_UPDATE;
         end
         cpr_pkg::ST_UPDATE: begin
            state_in = last_ff ? cpr_pkg::ST_DIV_SETUP : cpr_pkg::ST_IDLE;
         end
         cpr_pkg::ST_DIV_SETUP: state_in = cpr_pkg::ST_DIV_CHECK;
         cpr_pkg::ST_DIV_CHECK: begin
            if (refine_ff && (diff_abs < den_abs)) begin
               state_in = cpr_pkg::ST_DIV_STEP;
            end else begin
               state_in = cpr_pkg::ST_FINISH;
            end
         end
         cpr_pkg::ST_DIV_STEP: begin
            if (iter_ff == '0) state_in = cpr_pkg::ST_FINISH;
         end
         cpr_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               out_load = 1'b1;
               state_in = cpr_pkg::ST_IDLE;
            end
         end
         default: state_in = cpr_pkg::ST_IDLE;
      endcase
   end

   // sample capture
   always_ff @(posedge clock) begin
      if (accept) begin
         re_ff   <= req_sample_re;
         im_ff   <= req_sample_im;
         last_ff <= req_last;
      end
   end

   // squaring, square root and division datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         cpr_pkg::ST_MUL_RE: begin
            prod_ff <= RAD_W'(mul_prod);
         end
         cpr_pkg::ST_MUL_IM: begin
            prod_ff <= RAD_W'(mul_prod);
            rad_ff  <= prod_ff;
         end
         cpr_pkg::ST_SUM: begin
            rad_ff  <= rad_ff + prod_ff;
            rem_ff  <= '0;
            root_ff <= '0;
            iter_ff <= ITER_W'(SB - 1);
         end
         cpr_pkg::ST_ROOT: begin
            rad_ff  <= {rad_ff[RAD_W-3:0], 2'b00};
            iter_ff <= iter_ff - 1'b1;
            if (rem_shift >= rem_trial) begin
               rem_ff  <= rem_shift - rem_trial;
               root_ff <= {root_ff[SB-2:0], 1'b1};
            end else begin
               rem_ff  <= rem_shift;
               root_ff <= {root_ff[SB-2:0], 1'b0};
            end
         end
         cpr_pkg::ST_DIV_SETUP: begin
            diff_ff   <= diff_calc;
            den_ff    <= den_calc;
            refine_ff <= (best_pos_ff != '0) && !right_pend_ff && (den_calc != '0);
         end
         cpr_pkg::ST_DIV_CHECK: begin
            neg_ff  <= diff_ff[DEN_W-1] ^ den_ff[DEN_W-1];
            dabs_ff <= den_abs;
            drem_ff <= diff_abs;
            done_ff <= refine_ff;
            iter_ff <= ITER_W'(cpr_pkg::FRAC_SHIFT - 1);
            if (refine_ff && (diff_abs >= den_abs)) begin
               quot_ff <= Q_W'(1) << cpr_pkg::FRAC_SHIFT;
            end else begin
               quot_ff <= '0;
            end
         end
         cpr_pkg::ST_DIV_STEP: begin
            iter_ff <= iter_ff - 1'b1;
            if (drem_shift >= {1'b0, dabs_ff}) begin
               drem_ff <= DEN_W'(drem_shift - {1'b0, dabs_ff});
               quot_ff <= {quot_ff[Q_W-2:0], 1'b1};
            end else begin
               drem_ff <= DEN_W'(drem_shift);
               quot_ff <= {quot_ff[Q_W-2:0], 1'b0};
            end
         end
         default: begin
         end
      endcase
   end

   // peak search state, cleared after each result
   always_ff @(posedge clock) begin
      if (reset || out_load) begin
         best_mag_ff   <= '0;
         best_pos_ff   <= '0;
         left_mag_ff   <= '0;
         right_mag_ff  <= '0;
         prev_mag_ff   <= '0;
         count_ff      <= '0;
         right_pend_ff <= 1'b0;
         have_best_ff  <= 1'b0;
      end else if ((state_ff == cpr_pkg::ST_UPDATE) && in_range) begin
         if (!have_best_ff || (mag > best_mag_ff)) begin
            best_mag_ff   <= mag;
            best_pos_ff   <= count_ff[POS_W-1:0];
            left_mag_ff   <= (count_ff != '0) ? prev_mag_ff : '0;
            right_pend_ff <= 1'b1;
            have_best_ff  <= 1'b1;
         end else if (right_pend_ff) begin
            right_mag_ff  <= mag;
            right_pend_ff <= 1'b0;
         end
         prev_mag_ff <= mag;
         count_ff    <= count_ff + 1'b1;
      end
   end

   // result transaction valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_peak_ff   <= cpr_pkg::PEAK_W'(best_pos_ff);
         rsp_frac_ff   <= neg_ff ? $signed(-quot_ext) : $signed(quot_ext);
         rsp_interp_ff <= done_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_peak_index   = rsp_peak_ff;
   assign rsp_frac_offset  = rsp_frac_ff;
   assign rsp_interpolated = rsp_interp_ff;

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// testbench for the impulse response peak finder with parabolic refinement
`timescale 1ns / 1ps

module tb_top;

   localparam int SB           = cpr_pkg::SAMPLE_BITS_DEF;
   localparam int MAG_W        = SB + 1;
   localparam int PEAK_W       = cpr_pkg::PEAK_W;
   localparam int FRAC_W       = cpr_pkg::FRAC_W;
   localparam int FRAC_SHIFT   = cpr_pkg::FRAC_SHIFT;
   localparam int MAX_LEN      = cpr_pkg::MAX_LENGTH_DEF;
   localparam int DIR_ROWS     = 21;
   localparam int HOLD_CYCLES  = 3000;
   localparam int QUIET_LIMIT  = 20000;
   localparam int DRAIN_CYCLES = 60;

   typedef struct {
      logic [PEAK_W-1:0]        peak;
      logic signed [FRAC_W-1:0] frac;
      logic                     interp;
   } peak_result_type;

   // one directed transaction, with a typed-in result where it is obvious
   typedef struct {
      logic signed [SB-1:0]     re;
      logic signed [SB-1:0]     im;
      logic                     last;
      logic                     fixed;
      logic [PEAK_W-1:0]        peak;
      logic signed [FRAC_W-1:0] frac;
      logic                     interp;
   } sample_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic signed [SB-1:0]     req_sample_re = '0;
   logic signed [SB-1:0]     req_sample_im = '0;
   logic                     req_last = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [PEAK_W-1:0]        rsp_peak_index;
   logic signed [FRAC_W-1:0] rsp_frac_offset;
   logic                     rsp_interpolated;

   // typed-in expectation riding along with the current sample
   logic                     fix_on = 1'b0;
   logic [PEAK_W-1:0]        fix_peak = '0;
   logic signed [FRAC_W-1:0] fix_frac = '0;
   logic                     fix_interp = 1'b0;

   int send_idle_pct = 32;
   int rsp_idle_pct  = 75;
   bit hold_pending  = 1'b0;
   int error_count   = 0;
   int quiet_cycles  = 0;

   peak_result_type peak_results_q[$];

   // running search state of the predictor
   logic [MAG_W-1:0]  pk_best       = '0;
   logic [PEAK_W-1:0] pk_pos        = '0;
   logic [MAG_W-1:0]  pk_left       = '0;
   logic [MAG_W-1:0]  pk_right      = '0;
   logic [MAG_W-1:0]  pk_prev       = '0;
   logic [12:0]       pk_count      = '0;
   logic              pk_right_wait = 1'b0;
   logic              pk_have       = 1'b0;

   sample_row_type dir_table [DIR_ROWS] = '{
      // single zero sample: too short to refine
      '{0, 0, 1, 1, 0, 0, 0},
      // full scale peak in the middle
      '{100, 0, 0, 0, 0, 0, 0},
      '{-32768, -32768, 0, 0, 0, 0, 0},
      '{0, 0, 1, 0, 0, 0, 0},
      // rising to the final sample: peak at the end
      '{1, 0, 0, 0, 0, 0, 0},
      '{2, 0, 0, 0, 0, 0, 0},
      '{32767, 32767, 1, 1, 2, 0, 0},
      // equal magnitudes: the first one keeps the peak
      '{5, 0, 0, 0, 0, 0, 0},
      '{0, 5, 0, 0, 0, 0, 0},
      '{3, -4, 1, 1, 0, 0, 0},
      // right neighbor equals the peak: offset at plus half
      '{0, 0, 0, 0, 0, 0, 0},
      '{100, 0, 0, 0, 0, 0, 0},
      '{0, -100, 1, 1, 1, 16384, 1},
      // length two
      '{0, 0, 0, 0, 0, 0, 0},
      '{1, 0, 1, 1, 1, 0, 0},
      // peak at the first sample
      '{-9, 0, 0, 0, 0, 0, 0},
      '{1, 0, 0, 0, 0, 0, 0},
      '{2, 2, 1, 1, 0, 0, 0},
      // negative extremes on both parts
      '{-32768, 100, 0, 0, 0, 0, 0},
      '{32767, -32768, 0, 0, 0, 0, 0},
      '{-32768, 0, 1, 0, 0, 0, 0}
   };

   cir_peak_parabolic_refine_top u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample_re    (req_sample_re),
      .req_sample_im    (req_sample_im),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_peak_index   (rsp_peak_index),
      .rsp_frac_offset  (rsp_frac_offset),
      .rsp_interpolated (rsp_interpolated)
   );

   always #5 clock = ~clock;

   // integer square root, one result bit per trial
   function automatic logic [MAG_W-1:0] isqrt_floor(input longint x);
      longint acc;
      longint trial;
      acc = 0;
      for (int b = MAG_W - 1; b >= 0; b--) begin
         trial = acc | (longint'(1) << b);
         if (trial * trial <= x) acc = trial;
      end
      return acc[MAG_W-1:0];
   endfunction

   // advance the peak search by one sample, emit the refined peak on last
   task automatic track_sample(input logic signed [SB-1:0] re, input logic signed [SB-1:0] im,
                               input logic last, output logic emitted,
                               output peak_result_type res);
      longint sq;
      longint l;
      longint c;
      longint r;
      longint den;
      longint q;
      logic [MAG_W-1:0] mag;
      sq  = longint'(re) * longint'(re) + longint'(im) * longint'(im);
      mag = isqrt_floor(sq);
      if (pk_count < MAX_LEN) begin
         if (!pk_have || mag > pk_best) begin
            pk_best       = mag;
            pk_pos        = pk_count[PEAK_W-1:0];
            pk_left       = (pk_count != 0) ? pk_prev : '0;
            pk_right_wait = 1'b1;
            pk_have       = 1'b1;
         end else if (pk_right_wait) begin
            pk_right      = mag;
            pk_right_wait = 1'b0;
         end
         pk_prev  = mag;
         pk_count = pk_count + 1'b1;
      end
      emitted    = last;
      res.peak   = '0;
      res.frac   = '0;
      res.interp = 1'b0;
      if (last) begin
         q = 0;
         if (pk_pos != 0 && !pk_right_wait) begin
            l   = pk_left;
            c   = pk_best;
            r   = pk_right;
            den = l - 2 * c + r;
            if (den != 0) begin
               q = ((l - r) * (longint'(1) << FRAC_SHIFT)) / den;
               if (q > (longint'(1) << FRAC_SHIFT)) q = longint'(1) << FRAC_SHIFT;
               if (q < -(longint'(1) << FRAC_SHIFT)) q = -(longint'(1) << FRAC_SHIFT);
               res.interp = 1'b1;
            end
         end
         res.peak = pk_pos;
         res.frac = q[FRAC_W-1:0];
         // fresh search for the next response
         pk_best       = '0;
         pk_pos        = '0;
         pk_left       = '0;
         pk_right      = '0;
         pk_prev       = '0;
         pk_count      = '0;
         pk_right_wait = 1'b0;
         pk_have       = 1'b0;
      end
   endtask

   // offer one sample, with random idle cycles ahead of it
   task automatic send_sample(input logic signed [SB-1:0] re, input logic signed [SB-1:0] im,
                              input logic last, input logic fixed,
                              input logic [PEAK_W-1:0] peak,
                              input logic signed [FRAC_W-1:0] frac, input logic interp);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_sample_re <= re;
      req_sample_im <= im;
      req_last      <= last;
      fix_on        <= fixed;
      fix_peak      <= peak;
      fix_frac      <= frac;
      fix_interp    <= interp;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // one random response of a random shape
   task automatic send_response(input int len);
      int style;
      int peak_at;
      int amp;
      int slope;
      int d;
      int v;
      logic signed [SB-1:0] re;
      logic signed [SB-1:0] im;
      style   = $urandom_range(0, 9);
      peak_at = $urandom_range(0, len - 1);
      amp     = $urandom_range(1000, 32767);
      slope   = $urandom_range(1, 4000);
      v       = $urandom_range(0, 7);
      for (int i = 0; i < len; i++) begin
         if (style < 3) begin
            // noise over the full range
            re = SB'($urandom());
            im = SB'($urandom());
         end else if (style < 8) begin
            // a single hump, the usual shape of a response
            d = i - peak_at;
            if (d < 0) d = -d;
            v = amp - slope * d + $urandom_range(0, 63);
            if (v < 0) v = 0;
            if (v > 32767) v = 32767;
            re = $urandom_range(0, 1) ? SB'(v) : SB'(-v);
            im = SB'(int'($urandom_range(0, 255)) - 128);
         end else if (style == 8) begin
            // tiny values, many ties
            re = SB'(int'($urandom_range(0, 14)) - 7);
            im = SB'(int'($urandom_range(0, 14)) - 7);
         end else begin
            // flat response
            re = SB'(v);
            im = '0;
         end
         send_sample(re, im, i == len - 1, 1'b0, '0, '0, 1'b0);
      end
   endtask

   task automatic send_random(input int target);
      int sent;
      int pick;
      int len;
      sent = 0;
      while (sent < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 15) len = $urandom_range(1, 3);
         else if (pick < 90) len = $urandom_range(4, 40);
         else len = $urandom_range(41, 300);
         send_response(len);
         sent += len;
      end
   endtask

   // predict on every accepted sample
   always @(posedge clock) begin : req_monitor
      peak_result_type pred;
      logic emitted;
      if (!reset && req_valid && !req_stall) begin
         track_sample(req_sample_re, req_sample_im, req_last, emitted, pred);
         if (emitted) begin
            if (fix_on) begin
               pred.peak   = fix_peak;
               pred.frac   = fix_frac;
               pred.interp = fix_interp;
            end
            peak_results_q.push_back(pred);
         end
      end
   end

   // compare every accepted result with the oldest prediction
   always @(posedge clock) begin : rsp_monitor
      peak_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (peak_results_q.size() == 0) begin
            $error("result with nothing pending: peak_index %0d frac_offset %0d",
                   rsp_peak_index, rsp_frac_offset);
            error_count++;
         end else begin
            want = peak_results_q.pop_front();
            if (rsp_peak_index !== want.peak) begin
               $error("peak_index expected %0d got %0d", want.peak, rsp_peak_index);
               error_count++;
            end
            if (rsp_frac_offset !== want.frac) begin
               $error("frac_offset expected %0d got %0d", want.frac, rsp_frac_offset);
               error_count++;
            end
            if (rsp_interpolated !== want.interp) begin
               $error("interpolated expected %0d got %0d", want.interp, rsp_interpolated);
               error_count++;
            end
         end
      end
   end

   // result side backpressure, with one long hold-off on request
   initial begin
      @(posedge clock);
      forever begin
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);
            @(posedge clock);
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // main sequence
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      for (int i = 0; i < DIR_ROWS; i++) begin
         send_sample(dir_table[i].re, dir_table[i].im, dir_table[i].last, dir_table[i].fixed,
                     dir_table[i].peak, dir_table[i].frac, dir_table[i].interp);
      end

      // random responses under three idling mixes
      send_random(500);
      send_idle_pct = 75;
      rsp_idle_pct  = 32;
      send_random(500);
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      hold_pending  = 1'b1;
      send_random(500);
      req_valid <= 1'b0;

      // drain
      wait (peak_results_q.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

FILE: filelist.f
design/cpr_pkg.sv
design/cir_peak_parabolic_refine_top.sv
tb/tb_top.sv
